FILE: rtl/core/barc_pkg.sv
// Shared types and constants for the barometer raw compensation block.
// No dependencies; imported by every module of the block.
`default_nettype none
package barc_pkg;

   localparam int unsigned RawWidth      = 20;
   localparam int unsigned CoefWidth     = 16;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned CsrIndexWidth = 4;
   localparam int unsigned DivBits       = 64;
   localparam int unsigned FrontStages   = 9;
   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [CsrIndexWidth-1:0] CsrTempOffset = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CsrTempLinear = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CsrTempSquare = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CsrPressScale = 4'd3;
   localparam logic [CsrIndexWidth-1:0] CsrPressC23   = 4'd4;
   localparam logic [CsrIndexWidth-1:0] CsrPressC45   = 4'd5;
   localparam logic [CsrIndexWidth-1:0] CsrPressC67   = 4'd6;
   localparam logic [CsrIndexWidth-1:0] CsrPressC89   = 4'd7;

   typedef struct packed {
      logic [CoefWidth-1:0] t1;
      logic [CoefWidth-1:0] t2;
      logic [CoefWidth-1:0] t3;
      logic [CoefWidth-1:0] p1;
      logic [CoefWidth-1:0] p2;
      logic [CoefWidth-1:0] p3;
      logic [CoefWidth-1:0] p4;
      logic [CoefWidth-1:0] p5;
      logic [CoefWidth-1:0] p6;
      logic [CoefWidth-1:0] p7;
      logic [CoefWidth-1:0] p8;
      logic [CoefWidth-1:0] p9;
   } barc_cfg_type;

   typedef struct packed {
      logic [RawWidth-1:0] press;
      logic [31:0]         fine;
      logic [15:0]         tcent;
      logic [63:0]         numer;
      logic [63:0]         denom;
   } barc_job_type;

   typedef struct packed {
      logic [31:0] fine;
      logic [15:0] tcent;
      logic        zero;
      logic        neg;
   } barc_side_type;

endpackage
`default_nettype wire

FILE: rtl/core/barc_front.sv
// Front pipeline: accepts raw readings, computes temperature and the pressure
// terms up to the divisor. Depends on barc_pkg.
`default_nettype none
module barc_front
   import barc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire barc_cfg_type        cfg,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [RawWidth-1:0] req_raw_temperature,
   input  wire logic [RawWidth-1:0] req_raw_pressure,
   input  wire logic                queue_full,
   output logic                     push,
   output barc_job_type             job
);

   logic [FrontStages-1:0] vld_ff;
   logic                   en;

   logic [RawWidth-1:0] ap_ff [FrontStages];
   logic [RawWidth-1:0] at_ff;
   logic [31:0]         m1_ff, m2_ff, v1_ff, m3_ff, tf_ff;
   logic [31:0]         fine_ff [4:FrontStages-1];
   logic [15:0]         tcent_ff [4:FrontStages-1];
   logic signed [33:0]  a0_ff;
   logic [63:0]         sq_ff, sq6_ff, sq3_ff, b_ff, b9_ff, a2_ff, m_ff;
   logic signed [49:0]  ap5_ff, ap2_ff, ap5b_ff, ap2b_ff;

   logic [31:0]         d1, d2, t2x, t3x, m1_in, m2_in, v1_in, m3_in, tf_in, t5;
   logic signed [31:0]  tc;
   logic [15:0]         tcent_in;
   logic signed [33:0]  a0_in;
   logic signed [67:0]  sq_full;
   logic signed [15:0]  p5s, p2s;
   logic signed [49:0]  ap5_in, ap2_in;
   logic [63:0]         sq6_in, sq3_in, b_in, a2_in, m_in;

   assign en        = !vld_ff[FrontStages-1] || !queue_full;
   assign req_ready = en;
   assign push      = vld_ff[FrontStages-1] && !queue_full;

   always_comb begin
      t2x    = {{16{cfg.t2[15]}}, cfg.t2};
      t3x    = {{16{cfg.t3[15]}}, cfg.t3};
      d1     = {15'b0, at_ff[19:3]} - {15'b0, cfg.t1, 1'b0};
      d2     = {16'b0, at_ff[19:4]} - {16'b0, cfg.t1};
      m1_in  = d1 * t2x;
      m2_in  = d2 * d2;
      v1_in  = 32'($signed(m1_ff) >>> 11);
      m3_in  = 32'($signed(m2_ff) >>> 12) * t3x;
      tf_in  = v1_ff + 32'($signed(m3_ff) >>> 14);
      t5     = tf_ff * 32'd5 + 32'd128;
      tc     = $signed(t5) >>> 8;
      if (tc < -32'sd32768) begin
         tcent_in = 16'h8000;
      end else if (tc > 32'sd32767) begin
         tcent_in = 16'h7fff;
      end else begin
         tcent_in = tc[15:0];
      end
      a0_in   = $signed({{2{tf_ff[31]}}, tf_ff}) - 34'sd128000;
      p5s     = $signed(cfg.p5);
      p2s     = $signed(cfg.p2);
      sq_full = a0_ff * a0_ff;
      ap5_in  = a0_ff * p5s;
      ap2_in  = a0_ff * p2s;
      sq6_in  = sq_ff * {{48{cfg.p6[15]}}, cfg.p6};
      sq3_in  = sq_ff * {{48{cfg.p3[15]}}, cfg.p3};
      b_in    = sq6_ff + ({{14{ap5b_ff[49]}}, ap5b_ff} << 17)
                + ({{48{cfg.p4[15]}}, cfg.p4} << 35);
      a2_in   = 64'($signed(sq3_ff) >>> 8) + ({{14{ap2b_ff[49]}}, ap2b_ff} << 12);
      m_in    = (64'h0000_8000_0000_0000 + a2_ff) * {48'b0, cfg.p1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FrontStages-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         at_ff    <= req_raw_temperature;
         ap_ff[0] <= req_raw_pressure;
         for (int i = 1; i < FrontStages; i++) begin
            ap_ff[i] <= ap_ff[i-1];
         end
         for (int i = 5; i < FrontStages; i++) begin
            fine_ff[i]  <= fine_ff[i-1];
            tcent_ff[i] <= tcent_ff[i-1];
         end
         m1_ff       <= m1_in;
         m2_ff       <= m2_in;
         v1_ff       <= v1_in;
         m3_ff       <= m3_in;
         tf_ff       <= tf_in;
         fine_ff[4]  <= tf_ff;
         tcent_ff[4] <= tcent_in;
         a0_ff       <= a0_in;
         sq_ff       <= sq_full[63:0];
         ap5_ff      <= ap5_in;
         ap2_ff      <= ap2_in;
         sq6_ff      <= sq6_in;
         sq3_ff      <= sq3_in;
         ap5b_ff     <= ap5_ff;
         ap2b_ff     <= ap2_ff;
         b_ff        <= b_in;
         a2_ff       <= a2_in;
         b9_ff       <= b_ff;
         m_ff        <= m_in;
      end
   end

   always_comb begin
      job.press = ap_ff[FrontStages-1];
      job.fine  = fine_ff[FrontStages-1];
      job.tcent = tcent_ff[FrontStages-1];
      job.numer = b9_ff;
      job.denom = 64'($signed(m_ff) >>> 33);
   end

endmodule
`default_nettype wire

FILE: rtl/core/barc_queue.sv
// Small request queue between the front and back pipelines.
// Depends on barc_pkg.
`default_nettype none
module barc_queue
   import barc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire barc_job_type push_job,
   output logic              full,
   input  wire logic         pop,
   output logic              empty,
   output barc_job_type      pop_job
);

   barc_job_type             mem [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrWidth:0]   count_ff;

   assign full    = (count_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign pop_job = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QueuePtrWidth+1)'(QueueDepth))
      else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/core/barc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on barc_pkg.
`default_nettype none
module barc_div
   import barc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [DivBits-1:0] in_numer,
   input  wire logic [DivBits-1:0] in_denom,
   input  wire barc_side_type      in_side,
   output logic                    out_valid,
   output logic [DivBits-1:0]      out_quot,
   output barc_side_type           out_side
);

   logic [DivBits:0]   vld_ff;
   logic [DivBits-1:0] rem_ff [DivBits];
   logic [DivBits-1:0] dvd_ff [DivBits+1];
   logic [DivBits-1:0] den_ff [DivBits];
   barc_side_type      side_ff [DivBits+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DivBits-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         dvd_ff[0]  <= in_numer;
         den_ff[0]  <= in_denom;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < DivBits; i++) begin : g_stage
      logic [DivBits:0] shifted;
      logic             take;
      always_comb begin
         shifted = {rem_ff[i], dvd_ff[i][DivBits-1]};
         take    = (shifted >= {1'b0, den_ff[i]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[i+1]  <= {dvd_ff[i][DivBits-2:0], take};
            side_ff[i+1] <= side_ff[i];
         end
      end
      if (i < DivBits-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1] <= take ? DivBits'(shifted - {1'b0, den_ff[i]})
                                   : shifted[DivBits-1:0];
               den_ff[i+1] <= den_ff[i];
            end
         end
      end
   end

   assign out_valid = vld_ff[DivBits];
   assign out_quot  = dvd_ff[DivBits];
   assign out_side  = side_ff[DivBits];

endmodule
`default_nettype wire

FILE: rtl/core/barc_back.sv
// Back pipeline: pressure numerator, signed division and final correction.
// Depends on barc_pkg and barc_div.
`default_nettype none
module barc_back
   import barc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire barc_cfg_type cfg,
   input  wire logic         queue_empty,
   output logic              pop,
   input  wire barc_job_type job,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [15:0]       rsp_temperature_centi,
   output logic [31:0]       rsp_fine_temperature,
   output logic [31:0]       rsp_pressure_q24_8,
   output logic              rsp_pressure_invalid
);

   logic          en;
   logic          b1_vld_ff, b2_vld_ff, p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   logic          out_vld_ff;
   logic [63:0]   x_ff, den1_ff, num_ff, den2_ff;
   barc_side_type s1_ff, s2_ff, sp1_ff, sp2_ff, sp3_ff, sp4_ff;
   logic [63:0]   q1_ff, q2_ff, q3_ff, q4_ff, mll_ff, pp8_ff, ss_ff, w2_ff, w2b_ff, pp9_ff;
   logic [31:0]   mhl_ff;
   logic [15:0]   tcent_ff;
   logic [31:0]   fine_ff, press_ff;
   logic          inval_ff;

   logic [63:0]   p0, x_in, num_in, nabs, dabs, q_in, s, mll_in, pp8_in, ss_in;
   logic [63:0]   w2_in, pp9_in, sum, pf;
   logic [31:0]   mhl_in;
   barc_side_type s_in, div_side;
   logic          div_vld;
   logic [63:0]   div_quot;

   assign en   = !out_vld_ff || rsp_ready;
   assign pop  = !queue_empty && en;

   always_comb begin
      p0       = 64'd1048576 - {44'b0, job.press};
      x_in     = (p0 << 31) - job.numer;
      num_in   = x_ff * 64'd3125;
      nabs     = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      dabs     = den2_ff[63] ? (64'd0 - den2_ff) : den2_ff;
      s_in       = s2_ff;
      s_in.neg   = num_ff[63] ^ den2_ff[63];
      s_in.zero  = (den2_ff == '0);
      q_in     = div_side.neg ? (64'd0 - div_quot) : div_quot;
      s        = 64'($signed(q1_ff) >>> 13);
      mll_in   = {32'b0, s[31:0]} * {32'b0, s[31:0]};
      mhl_in   = s[63:32] * s[31:0];
      pp8_in   = q1_ff * {{48{cfg.p8[15]}}, cfg.p8};
      ss_in    = mll_ff + {mhl_ff[30:0], 33'b0};
      w2_in    = 64'($signed(pp8_ff) >>> 19);
      pp9_in   = ss_ff * {{48{cfg.p9[15]}}, cfg.p9};
      sum      = q4_ff + 64'($signed(pp9_ff) >>> 25) + w2b_ff;
      pf       = 64'($signed(sum) >>> 8) + ({{48{cfg.p7[15]}}, cfg.p7} << 4);
   end

   barc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b2_vld_ff),
      .in_numer  (nabs),
      .in_denom  (dabs),
      .in_side   (s_in),
      .out_valid (div_vld),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         p4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         b1_vld_ff  <= pop;
         b2_vld_ff  <= b1_vld_ff;
         p1_vld_ff  <= div_vld;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         p4_vld_ff  <= p3_vld_ff;
         out_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff        <= x_in;
         den1_ff     <= job.denom;
         s1_ff.fine  <= job.fine;
         s1_ff.tcent <= job.tcent;
         s1_ff.zero  <= 1'b0;
         s1_ff.neg   <= 1'b0;
         num_ff      <= num_in;
         den2_ff     <= den1_ff;
         s2_ff       <= s1_ff;
         q1_ff       <= q_in;
         sp1_ff      <= div_side;
         mll_ff      <= mll_in;
         mhl_ff      <= mhl_in;
         pp8_ff      <= pp8_in;
         q2_ff       <= q1_ff;
         sp2_ff      <= sp1_ff;
         ss_ff       <= ss_in;
         w2_ff       <= w2_in;
         q3_ff       <= q2_ff;
         sp3_ff      <= sp2_ff;
         pp9_ff      <= pp9_in;
         w2b_ff      <= w2_ff;
         q4_ff       <= q3_ff;
         sp4_ff      <= sp3_ff;
         tcent_ff    <= sp4_ff.tcent;
         fine_ff     <= sp4_ff.fine;
         press_ff    <= sp4_ff.zero ? 32'd0 : pf[31:0];
         inval_ff    <= sp4_ff.zero;
      end
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_temperature_centi = tcent_ff;
   assign rsp_fine_temperature  = fine_ff;
   assign rsp_pressure_q24_8    = press_ff;
   assign rsp_pressure_invalid  = inval_ff;

endmodule
`default_nettype wire

FILE: rtl/core/barometer_raw_compensation.sv
// Top level of the barometer raw compensation block: calibration registers,
// front pipeline, request queue and back pipeline. Depends on barc_pkg and all barc_ modules.
//
// Takes one raw temperature/pressure request per clock unless a full queue holds back
// req_ready, and returns one result per request, in order. With no stalls a request
// passes 82 register stages: 9 front stages, one queue slot, 2 numerator stages, 65
// divider stages and 5 correction stages; the divider resolves one quotient bit per
// stage. Calibration writes are taken every cycle and must only happen while no
// request is in flight.
`default_nettype none
module barometer_raw_compensation
   import barc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [RawWidth-1:0]      req_raw_temperature,
   input  wire logic [RawWidth-1:0]      req_raw_pressure,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [15:0]                   rsp_temperature_centi,
   output logic [31:0]                   rsp_fine_temperature,
   output logic [31:0]                   rsp_pressure_q24_8,
   output logic                          rsp_pressure_invalid
);

   barc_cfg_type cfg_ff;
   logic         push, pop, full, empty;
   barc_job_type push_job, pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrTempOffset: cfg_ff.t1 <= csr_data[15:0];
            CsrTempLinear: cfg_ff.t2 <= csr_data[15:0];
            CsrTempSquare: cfg_ff.t3 <= csr_data[15:0];
            CsrPressScale: cfg_ff.p1 <= csr_data[15:0];
            CsrPressC23: begin
               cfg_ff.p2 <= csr_data[15:0];
               cfg_ff.p3 <= csr_data[31:16];
            end
            CsrPressC45: begin
               cfg_ff.p4 <= csr_data[15:0];
               cfg_ff.p5 <= csr_data[31:16];
            end
            CsrPressC67: begin
               cfg_ff.p6 <= csr_data[15:0];
               cfg_ff.p7 <= csr_data[31:16];
            end
            CsrPressC89: begin
               cfg_ff.p8 <= csr_data[15:0];
               cfg_ff.p9 <= csr_data[31:16];
            end
            default: begin
            end
         endcase
      end
   end

   barc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_temperature (req_raw_temperature),
      .req_raw_pressure    (req_raw_pressure),
      .queue_full          (full),
      .push                (push),
      .job                 (push_job)
   );

   barc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_job  (pop_job)
   );

   barc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .queue_empty           (empty),
      .pop                   (pop),
      .job                   (pop_job),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_fine_temperature  (rsp_fine_temperature),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_pressure_invalid  (rsp_pressure_invalid)
   );

endmodule
`default_nettype wire

FILE: tb/barc_checker.sv
// Checker for barometer_raw_compensation: watches the calibration, request and result channels.
// Predicts each result from its own copy of the calibration; depends on barc_pkg.
`timescale 1ns / 100ps
module barc_checker
   import barc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [RawWidth-1:0]      req_raw_temperature,
   input  wire logic [RawWidth-1:0]      req_raw_pressure,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic [15:0]              rsp_temperature_centi,
   input  wire logic [31:0]              rsp_fine_temperature,
   input  wire logic [31:0]              rsp_pressure_q24_8,
   input  wire logic                     rsp_pressure_invalid,
   output int                            err_count,
   output int                            pending
);

   typedef struct {
      logic [15:0] tcent;
      logic [31:0] fine;
      logic [31:0] press;
      logic        invalid;
   } reading_type;

   logic [31:0] coeff_reg [8];
   reading_type readings_due[$];

   function automatic logic [63:0] sx16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic reading_type compensate(input logic [19:0] rt, input logic [19:0] rp);
      logic [31:0] t1, t2, t3, d1, d2, v1, v2, tf, tc, m;
      logic [63:0] a, b, c, p, s, w1, w2, num, ma, md, q;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      reading_type r;
      t1 = {16'h0, coeff_reg[CsrTempOffset][15:0]};
      t2 = {{16{coeff_reg[CsrTempLinear][15]}}, coeff_reg[CsrTempLinear][15:0]};
      t3 = {{16{coeff_reg[CsrTempSquare][15]}}, coeff_reg[CsrTempSquare][15:0]};
      d1 = ({12'h0, rt} >> 3) - (t1 << 1);
      m = d1 * t2;
      v1 = $signed(m) >>> 11;
      d2 = ({12'h0, rt} >> 4) - t1;
      m = d2 * d2;
      m = $signed(m) >>> 12;
      m = m * t3;
      v2 = $signed(m) >>> 14;
      tf = v1 + v2;
      m = tf * 32'd5 + 32'd128;
      tc = $signed(m) >>> 8;
      if ($signed(tc) < -32768) r.tcent = 16'h8000;
      else if ($signed(tc) > 32767) r.tcent = 16'h7fff;
      else r.tcent = tc[15:0];
      r.fine = tf;

      p1 = {48'h0, coeff_reg[CsrPressScale][15:0]};
      p2 = sx16(coeff_reg[CsrPressC23][15:0]);
      p3 = sx16(coeff_reg[CsrPressC23][31:16]);
      p4 = sx16(coeff_reg[CsrPressC45][15:0]);
      p5 = sx16(coeff_reg[CsrPressC45][31:16]);
      p6 = sx16(coeff_reg[CsrPressC67][15:0]);
      p7 = sx16(coeff_reg[CsrPressC67][31:16]);
      p8 = sx16(coeff_reg[CsrPressC89][15:0]);
      p9 = sx16(coeff_reg[CsrPressC89][31:16]);
      a = {{32{tf[31]}}, tf} - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      c = a * a * p3;
      c = $signed(c) >>> 8;
      c = c + ((a * p2) << 12);
      c = ((64'd1 << 47) + c) * p1;
      c = $signed(c) >>> 33;
      if (c == 64'd0) begin
         r.press = 32'd0;
         r.invalid = 1'b1;
      end else begin
         p = 64'd1048576 - {44'h0, rp};
         num = ((p << 31) - b) * 64'd3125;
         ma = num[63] ? -num : num;
         md = c[63] ? -c : c;
         q = ma / md;
         p = (num[63] != c[63]) ? -q : q;
         s = $signed(p) >>> 13;
         w1 = p9 * s * s;
         w1 = $signed(w1) >>> 25;
         w2 = p8 * p;
         w2 = $signed(w2) >>> 19;
         p = p + w1 + w2;
         p = $signed(p) >>> 8;
         p = p + (p7 << 4);
         r.press = p[31:0];
         r.invalid = 1'b0;
      end
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
      err_count++;
   endtask

   assign pending = readings_due.size();

   initial err_count = 0;

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         for (int i = 0; i < 8; i++) coeff_reg[i] = '0;
         readings_due.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < 8) begin
            if (csr_index < CsrPressC23) coeff_reg[csr_index] = {16'h0, csr_data[15:0]};
            else coeff_reg[csr_index] = csr_data;
         end
         if (req_valid && req_ready)
            readings_due.push_back(compensate(req_raw_temperature, req_raw_pressure));
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $display("%0t: result with no request outstanding", $realtime);
               err_count++;
            end else begin
               want = readings_due.pop_front();
               if (rsp_temperature_centi !== want.tcent)
                  report("temperature_centi", rsp_temperature_centi, want.tcent);
               if (rsp_fine_temperature !== want.fine)
                  report("fine_temperature", rsp_fine_temperature, want.fine);
               if (rsp_pressure_q24_8 !== want.press)
                  report("pressure_q24_8", rsp_pressure_q24_8, want.press);
               if (rsp_pressure_invalid !== want.invalid)
                  report("pressure_invalid", rsp_pressure_invalid, want.invalid);
            end
         end
      end
   end

endmodule

FILE: tb/tb.sv
// Testbench top for barometer_raw_compensation: clock, reset, calibration phases,
// bursty requests and a stalling receiver. Depends on barc_pkg and barc_checker.
`timescale 1ns / 100ps
module tb;
   import barc_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrUnmapped = 4'd15;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [RawWidth-1:0]      req_raw_temperature = '0;
   logic [RawWidth-1:0]      req_raw_pressure = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [15:0]              rsp_temperature_centi;
   logic [31:0]              rsp_fine_temperature;
   logic [31:0]              rsp_pressure_q24_8;
   logic                     rsp_pressure_invalid;
   int                       err_count;
   int                       pending;
   bit                       hold_off = 1'b0;
   int                       burst_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   barometer_raw_compensation u_top (.*);

   barc_checker u_checker (.*);

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_coeffs(input logic [15:0] t1, t2, t3, p1, input logic [31:0] c23, c45,
                              input logic [31:0] c67, c89);
      write_reg(CsrTempOffset, {16'h0, t1});
      write_reg(CsrTempLinear, {16'h0, t2});
      write_reg(CsrTempSquare, {16'h0, t3});
      write_reg(CsrPressScale, {16'h0, p1});
      write_reg(CsrPressC23, c23);
      write_reg(CsrPressC45, c45);
      write_reg(CsrPressC67, c67);
      write_reg(CsrPressC89, c89);
   endtask

   task automatic send(input logic [19:0] rt, input logic [19:0] rp);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid           <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure    <= rp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [19:0] raw_reading();
      if ($urandom_range(0, 9) < 7) return 20'($urandom_range(300000, 600000));
      return 20'($urandom);
   endfunction

   function automatic logic [15:0] coeff_near(input logic [15:0] base);
      return base ^ 16'($urandom_range(0, 255));
   endfunction

   // receiver: change stall pattern at random, honor long hold-off requests
   initial begin
      int mode;
      mode = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= $urandom_range(0, 9) != 0;
               default: rsp_ready <= $urandom_range(0, 3) == 0;
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_coeffs(16'd27504, 16'd26435, -16'sd1000, 16'd36477, {16'd3024, -16'sd10685},
                  {16'd140, 16'd2855}, {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
      send(20'd519888, 20'd415148);
      send(20'h00000, 20'h00000);
      send(20'hfffff, 20'hfffff);
      send(20'h00000, 20'hfffff);
      send(20'hfffff, 20'h00000);
      send(20'haaaaa, 20'h55555);
      send(20'h55555, 20'haaaaa);
      send(20'd540000, 20'd300000);
      send(20'd480000, 20'd600000);
      drain();

      // extreme coefficients: saturate temperature both ways, wrap the pressure path
      load_coeffs(16'h0000, 16'h7fff, 16'h7fff, 16'hffff, 32'h7fff7fff, 32'h7fff7fff,
                  32'h7fff7fff, 32'h7fff7fff);
      send(20'hfffff, 20'h00000);
      send(20'h00000, 20'hfffff);
      send(20'h80000, 20'h80000);
      drain();
      load_coeffs(16'hffff, 16'h8000, 16'h8000, 16'hffff, 32'h80008000, 32'h80008000,
                  32'h80008000, 32'h80008000);
      send(20'hfffff, 20'hfffff);
      send(20'h00000, 20'h00000);
      send(20'h7ffff, 20'h12345);
      drain();
      // zero pressure scale: divisor is zero
      load_coeffs(16'd27504, 16'd26435, -16'sd1000, 16'h0000, {16'd3024, -16'sd10685},
                  {16'd140, 16'd2855}, {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
      write_reg(CsrUnmapped, 32'hffffffff);
      send(20'd519888, 20'd415148);
      send(20'hfffff, 20'h00000);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_coeffs(coeff_near(16'd27504), coeff_near(16'd26435), coeff_near(-16'sd1000),
                           coeff_near(16'd36477), {coeff_near(16'd3024), coeff_near(-16'sd10685)},
                           {coeff_near(16'd140), coeff_near(16'd2855)},
                           {coeff_near(16'd15500), coeff_near(-16'sd7)},
                           {coeff_near(16'd6000), coeff_near(-16'sd14600)});
            1: load_coeffs(16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 32'h7fff7fff, 32'h7fff7fff,
                           32'h7fff7fff, 32'h7fff7fff);
            2: load_coeffs(16'h0000, 16'h8000, 16'h8000, 16'h0001, 32'h80008000, 32'h80008000,
                           32'h80008000, 32'h80008000);
            4: load_coeffs(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000, $urandom,
                           $urandom, $urandom, $urandom);
            default: begin
               load_coeffs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           $urandom, $urandom, $urandom, $urandom);
               write_reg(4'($urandom_range(8, 15)), $urandom);
            end
         endcase
         if (ph == 2) hold_off = 1'b1;
         for (int i = 0; i < 150; i++) begin
            if (ph == 3 && i == 75) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
               burst_left = 0;
            end
            send(raw_reading(), raw_reading());
         end
         drain();
      end

      if (err_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule
